// ----- rtl/set_assoc_write_back_cache_top_macros.svh -----
// Assertion macros for the set-associative write-back cache checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SET_ASSOC_WRITE_BACK_CACHE_TOP_MACROS_SVH
`define SET_ASSOC_WRITE_BACK_CACHE_TOP_MACROS_SVH

// Same-cycle implication.
`define SAWB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cache port check failed");

// Next-cycle implication.
`define SAWB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cache port check failed");

`endif

// ----- rtl/sawb_pkg.sv -----
// Shared types and codes for the set-associative write-back cache.
// No dependencies; imported by the top level and the way selection logic.
package sawb_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_INVALID = 2'd0;
    localparam t_status ST_VALID   = 2'd1;
    localparam t_status ST_DIRTY   = 2'd2;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Outcome of one lookup, from the way selection logic to the sequencer.
    typedef struct packed {
        logic       hit;
        logic       wrote_back;
        logic       row_we;
        logic [7:0] read_data;
    } t_pick;

endpackage

// ----- rtl/set_assoc_write_back_cache_top.sv -----
// Set-associative write-back cache, byte wide, with its own backing memory.
// A result takes longer when the set count is not a power of two: the set index unit
// adds a reciprocal multiply and a correction. One transaction is handled at a time: a new
// one is accepted only after the last result has moved into the output register, a move
// that waits while that register stays full; the set row memory is read once and written at most once.
// After reset a clearing pass wipes every set row before the first transaction.
module set_assoc_write_back_cache_top #(
    parameter int ADDR_BITS = 16,
    parameter int LINES     = 16,
    parameter int WAYS_LOG2 = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_peek,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_hit,
    output logic        o_wrote_back
);
    import sawb_pkg::*;

    localparam int WAYS  = 1 << WAYS_LOG2;
    localparam int NSETS = ((LINES >> WAYS_LOG2) > 0) ? (LINES >> WAYS_LOG2) : 1;
    localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1;
    localparam int PTR_W = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
    localparam int WAY_W = 2 + ADDR_BITS + 8;
    localparam int ROW_W = PTR_W + WAYS * WAY_W;
    localparam int MEM_D = 1 << ADDR_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SET   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [ROW_W-1:0]     line_mem [NSETS];
    logic [7:0]           back_mem [MEM_D];

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [SET_W-1:0]     r_clr;
    logic                 r_act;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0]           r_wd;
    logic                 r_peek;
    logic [SET_W-1:0]     r_set;
    logic [ROW_W-1:0]     r_row;
    logic [7:0]           r_mem_q;
    t_pick                r_res;
    logic                 r_out_valid;
    logic [7:0]           r_read_data;
    logic                 r_hit;
    logic                 r_wrote_back;

    logic                 accept;
    logic                 out_free;
    logic                 mod_done;
    logic [SET_W-1:0]     mod_set;
    logic [ROW_W-1:0]     n_row;
    t_pick                pick;
    logic [ADDR_BITS-1:0] wb_addr;
    logic [7:0]           wb_data;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    sawb_set_mod #(
        .ADDR_BITS (ADDR_BITS),
        .NSETS     (NSETS),
        .SET_W     (SET_W)
    ) u_set_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_addr  (ADDR_BITS'(i_address)),
        .o_done  (mod_done),
        .o_set   (mod_set)
    );

    sawb_way_pick #(
        .ADDR_BITS (ADDR_BITS),
        .WAYS_LOG2 (WAYS_LOG2),
        .PTR_W     (PTR_W),
        .ROW_W     (ROW_W)
    ) u_way_pick (
        .i_row     (r_row),
        .i_addr    (r_addr),
        .i_act     (r_act),
        .i_peek    (r_peek),
        .i_wd      (r_wd),
        .i_mem_q   (r_mem_q),
        .o_row     (n_row),
        .o_pick    (pick),
        .o_wb_addr (wb_addr),
        .o_wb_data (wb_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == SET_W'(NSETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                if (mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_LOOK;
            S_LOOK:  n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction fields, set index, lookup outcome and output payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_addr <= ADDR_BITS'(i_address);
            r_wd   <= i_write_data;
            r_peek <= i_peek;
        end
        if (r_state == S_SET && mod_done) begin
            r_set <= mod_set;
        end
        if (r_state == S_LOOK) begin
            r_res <= pick;
        end
        if (r_state == S_RESP && out_free) begin
            r_read_data  <= r_res.read_data;
            r_hit        <= r_res.hit;
            r_wrote_back <= r_res.wrote_back;
        end
    end

    // Set row memory: clearing pass, read in S_READ, write back in S_LOOK.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            line_mem[r_clr] <= '0;
        end else if (r_state == S_LOOK && pick.row_we) begin
            line_mem[r_set] <= n_row;
        end
        if (r_state == S_READ) begin
            r_row <= line_mem[r_set];
        end
    end

    // Backing memory: fetch the requested byte, then take the evicted line.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_mem_q <= back_mem[r_addr];
        end
        if (r_state == S_LOOK && pick.wrote_back) begin
            back_mem[wb_addr] <= wb_data;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_hit        = r_hit;
    assign o_wrote_back = r_wrote_back;

endmodule

// ----- rtl/sawb_set_mod.sv -----
// Set index unit: address modulo the number of sets.
// Power-of-two set counts take the masked low address bits; others use a reciprocal multiply
// and one correction step. No package dependency.
module sawb_set_mod #(
    parameter int ADDR_BITS = 16,
    parameter int NSETS     = 8,
    parameter int SET_W     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic                 o_done,
    output logic [SET_W-1:0]     o_set
);
    localparam bit SETS_POW2 = ((NSETS & (NSETS - 1)) == 0);
    localparam int EXT_W     = (ADDR_BITS > SET_W) ? ADDR_BITS : SET_W;
    localparam int REM_W     = (ADDR_BITS > SET_W + 1) ? ADDR_BITS : SET_W + 1;
    localparam int PROD_W    = 2 * ADDR_BITS;

    // Reciprocal of the set count scaled by 2^ADDR_BITS, rounded down.
    localparam logic [ADDR_BITS-1:0] RECIP  = ADDR_BITS'((1 << ADDR_BITS) / NSETS);
    localparam logic [ADDR_BITS-1:0] NSET_A = ADDR_BITS'(NSETS);
    localparam logic [REM_W-1:0]     NSET_R = REM_W'(NSETS);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_phase;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_quot;
    logic [SET_W-1:0]     r_rem;

    logic [EXT_W-1:0]     ext_addr;
    logic [SET_W-1:0]     masked;
    logic [PROD_W-1:0]    prod;
    logic [ADDR_BITS-1:0] quot_n;
    logic [ADDR_BITS-1:0] quot_mul;
    logic [REM_W-1:0]     diff;
    logic [SET_W-1:0]     n_rem;

    always_comb begin
        ext_addr = EXT_W'(i_addr);
        masked   = ext_addr[SET_W-1:0] & SET_W'(NSETS - 1);
        // The quotient estimate is low by at most one; one subtract corrects it.
        prod     = PROD_W'(r_addr) * PROD_W'(RECIP);
        quot_n   = prod[PROD_W-1:ADDR_BITS];
        quot_mul = r_quot * NSET_A;
        diff     = REM_W'(r_addr) - REM_W'(quot_mul);
        if (diff >= NSET_R) begin
            diff = diff - NSET_R;
        end
        n_rem    = diff[SET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (SETS_POW2) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                end
            end else if (r_busy) begin
                r_phase <= 1'b1;
                if (r_phase) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= SETS_POW2 ? masked : '0;
            r_addr <= i_addr;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_quot <= quot_n;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_set  = r_rem;

endmodule

// ----- rtl/sawb_way_pick.sv -----
// Way selection and row update for one set of the cache.
// Depends on sawb_pkg for status codes and the t_pick outcome struct.
module sawb_way_pick #(
    parameter int ADDR_BITS = 16,
    parameter int WAYS_LOG2 = 1,
    parameter int PTR_W     = 1,
    parameter int ROW_W     = 53
) (
    input  logic [ROW_W-1:0]     i_row,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic                 i_act,
    input  logic                 i_peek,
    input  logic [7:0]           i_wd,
    input  logic [7:0]           i_mem_q,
    output logic [ROW_W-1:0]     o_row,
    output sawb_pkg::t_pick      o_pick,
    output logic [ADDR_BITS-1:0] o_wb_addr,
    output logic [7:0]           o_wb_data
);
    import sawb_pkg::*;

    localparam int WAYS  = 1 << WAYS_LOG2;
    localparam int WAY_W = 2 + ADDR_BITS + 8;

    logic [WAYS-1:0]      match;
    logic [PTR_W-1:0]     ptr;
    logic [PTR_W-1:0]     n_ptr;
    logic [PTR_W-1:0]     hit_way;
    logic [PTR_W-1:0]     way;
    t_status              sel_st;
    logic [ADDR_BITS-1:0] sel_addr;
    logic [7:0]           sel_data;
    logic                 hit;
    logic                 upd_way;
    logic [WAY_W-1:0]     new_way;
    logic [7:0]           rd;

    always_comb begin
        ptr = i_row[PTR_W-1:0];
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (i_row[PTR_W + w*WAY_W + 8 + ADDR_BITS +: 2] != ST_INVALID)
                    && (i_row[PTR_W + w*WAY_W + 8 +: ADDR_BITS] == i_addr);
        end
        hit = |match;

        // Lowest matching way wins.
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = PTR_W'(w);
            end
        end

        n_ptr = (WAYS == 1) ? '0 : ptr + 1'b1;
        way   = hit ? hit_way : n_ptr;

        sel_st   = ST_INVALID;
        sel_addr = '0;
        sel_data = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (PTR_W'(w) == way) begin
                sel_st   = i_row[PTR_W + w*WAY_W + 8 + ADDR_BITS +: 2];
                sel_addr = i_row[PTR_W + w*WAY_W + 8 +: ADDR_BITS];
                sel_data = i_row[PTR_W + w*WAY_W +: 8];
            end
        end

        if (i_act == ACT_WRITE) begin
            upd_way = 1'b1;
            new_way = {ST_DIRTY, i_addr, i_wd};
            rd      = '0;
        end else if (i_peek) begin
            upd_way = 1'b0;
            new_way = {ST_VALID, i_addr, i_mem_q};
            rd      = hit ? sel_data : i_mem_q;
        end else begin
            upd_way = !hit;
            new_way = {ST_VALID, i_addr, i_mem_q};
            rd      = hit ? sel_data : i_mem_q;
        end

        // Advance the round-robin pointer on any miss, peek included.
        o_row = i_row;
        if (!hit) begin
            o_row[PTR_W-1:0] = n_ptr;
        end
        for (int w = 0; w < WAYS; w++) begin
            if (upd_way && (PTR_W'(w) == way)) begin
                o_row[PTR_W + w*WAY_W +: WAY_W] = new_way;
            end
        end

        o_pick.hit        = hit;
        o_pick.wrote_back = !hit && (sel_st == ST_DIRTY)
                         && ((i_act == ACT_WRITE) || !i_peek);
        o_pick.row_we     = (i_act == ACT_WRITE) || !hit;
        o_pick.read_data  = rd;
        o_wb_addr         = sel_addr;
        o_wb_data         = sel_data;
    end

endmodule

// ----- rtl/sawb_checker.sv -----
// Port-level checks for the set-associative write-back cache.
// Uses the assertion macros header; bound to set_assoc_write_back_cache_top.
`include "set_assoc_write_back_cache_top_macros.svh"

module sawb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_read_data,
    input logic        o_hit,
    input logic        o_wrote_back
);
    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // One transaction in flight: ready drops right after an accept.
    `SAWB_ASSERT_NXT(a_busy_after_accept, in_acc, !o_in_ready)

    // No result can appear in the cycle after an accept.
    `SAWB_ASSERT_NXT(a_no_early_result, in_acc, !$rose(o_out_valid))

    // A hit never evicts.
    `SAWB_ASSERT_IMP(a_hit_no_evict, o_out_valid, !(o_hit && o_wrote_back))

    // Hold a stalled result.
    `SAWB_ASSERT_NXT(a_result_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_read_data) && $stable(o_hit) && $stable(o_wrote_back))

endmodule

bind set_assoc_write_back_cache_top sawb_checker u_sawb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_data  (o_read_data),
    .o_hit        (o_hit),
    .o_wrote_back (o_wrote_back)
);
